/* hw/rtl/hidrsp_pkg.sv */
`timescale 1ns / 1ps
package hidrsp_pkg;

  // One byte of an incoming host-controller packet.
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_last;
    logic [1:0] direction;
  } in_word_t;

  // One byte of a generated reply packet.
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } out_word_t;

  // Everything the reply generator needs to build one reply packet.
  typedef struct packed {
    logic [11:0] link_handle;
    logic [15:0] remote_channel;
    logic [7:0]  report_number;
    logic [3:0]  rpt_len;
  } reply_req_t;

  localparam logic [7:0]  PKT_ACL         = 8'h02;
  localparam logic [15:0] CID_SIGNALLING  = 16'h0001;
  localparam logic [15:0] PSM_HID_CONTROL = 16'h0011;
  localparam logic [15:0] CID_MIN_DYNAMIC = 16'h0040;
  localparam logic [7:0]  CMD_CONN_REQ    = 8'h02;
  localparam logic [7:0]  CMD_CONN_RSP    = 8'h03;
  localparam logic [7:0]  HID_REQ_INPUT   = 8'h41;
  localparam logic [7:0]  HID_DATA_INPUT  = 8'ha1;
  localparam logic [1:0]  DIR_OUTGOING    = 2'd0;
  localparam logic [1:0]  DIR_INCOMING    = 2'd1;

  // Input report sizes in bytes; zero means the report id is unknown.
  function automatic logic [3:0] input_rpt_len(input logic [7:0] id);
    logic [3:0] size;
    unique case (id)
      8'h01:   size = 4'd9;
      8'h02:   size = 4'd8;
      8'h03:   size = 4'd5;
      8'h04:   size = 4'd2;
      8'hac:   size = 4'd2;
      8'had:   size = 4'd2;
      8'hff:   size = 4'd2;
      8'h10:   size = 4'd7;
      default: size = 4'd0;
    endcase
    return size;
  endfunction

endpackage

/* hw/rtl/hid_control_channel_report_responder.sv */
`timescale 1ns / 1ps
// This block watches a stream of raw host-controller packets, one byte per
// word, and answers requests for input reports on the HID control channel
// that it has seen opened on the signalling channel. The parser takes
// one word every clock cycle and classifies each byte as it arrives; when the
// final byte of a qualifying request is taken, a short reply descriptor is
// placed in a two-entry queue. The reply generator drains that queue on its
// own side, producing one reply word per cycle through a registered output
// unless out_ready holds it back; a reply is 12 to 19 bytes long, with an
// idle gap on the output between consecutive replies while the next descriptor is
// loaded. The input is stalled only while both queue entries are occupied.
// Packets longer than MAX_PACKET_BYTES keep their tail bytes out of the
// parse but still end at their last-byte flag. The single configuration bit
// enables replies and should be written while the block is idle.
module hid_control_channel_report_responder #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hidrsp_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hidrsp_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  logic                   enable_reply_r;
  logic                   in_fire;
  logic                   req_push;
  hidrsp_pkg::reply_req_t req_data;
  logic                   q_full;
  logic                   q_not_empty;
  logic                   q_pop;
  hidrsp_pkg::reply_req_t q_data;

  // A free queue entry is always held for the word in flight, so a reply
  // raised by the last byte of a packet never finds the queue full.
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_reply_r <= 1'b0;
    end else if (cfg_we) begin
      enable_reply_r <= cfg_wdata;
    end
  end

  hidrsp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data      (in_data),
    .enable_reply (enable_reply_r),
    .req_push     (req_push),
    .req_data     (req_data)
  );

  hidrsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  hidrsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* hw/rtl/hidrsp_front.sv */
`timescale 1ns / 1ps
module hidrsp_front #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  hidrsp_pkg::in_word_t  in_data,
  input  logic                  enable_reply,
  output logic                  req_push,
  output hidrsp_pkg::reply_req_t req_data
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [1:0]       dir_r, dir_nxt;
  logic [11:0]      handle_r, handle_nxt;
  logic [15:0]      l2len_r, l2len_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [7:0]       trans_r, trans_nxt;
  logic [7:0]       report_r, report_nxt;
  logic [POS_W-1:0] cmd_start_r, cmd_start_nxt;
  logic [7:0]       cmd_code_r, cmd_code_nxt;
  logic [15:0]      cmd_len_r, cmd_len_nxt;
  logic [7:0]       body_r [6];
  logic [7:0]       body_nxt [6];
  logic [15:0]      local_r, local_nxt;
  logic [15:0]      remote_r, remote_nxt;

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] off;
  logic [POS_W-1:0] off_m4;
  logic [7:0]       b;
  logic [15:0]      w0, w1, res;
  logic [3:0]       size;
  logic             reply_ok;

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    handle_nxt    = handle_r;
    l2len_nxt     = l2len_r;
    chan_nxt      = chan_r;
    trans_nxt     = trans_r;
    report_nxt    = report_r;
    cmd_start_nxt = cmd_start_r;
    cmd_code_nxt  = cmd_code_r;
    cmd_len_nxt   = cmd_len_r;
    body_nxt      = body_r;
    local_nxt     = local_r;
    remote_nxt    = remote_r;
    p      = byte_pos_r;
    b      = in_data.packet_byte;
    off    = p - cmd_start_r;
    off_m4 = off - POS_W'(4);
    w0 = '0;
    w1 = '0;
    res = '0;

    if (p < POS_W'(MAX_PACKET_BYTES)) begin
      if (p == POS_W'(0)) begin
        kind_nxt = b;
        dir_nxt  = in_data.direction;
      end else if (p == POS_W'(1)) begin
        handle_nxt[7:0] = b;
      end else if (p == POS_W'(2)) begin
        handle_nxt[11:8] = b[3:0];
      end else if (p == POS_W'(5)) begin
        l2len_nxt[7:0] = b;
      end else if (p == POS_W'(6)) begin
        l2len_nxt[15:8] = b;
      end else if (p == POS_W'(7)) begin
        chan_nxt[7:0] = b;
      end else if (p == POS_W'(8)) begin
        chan_nxt[15:8] = b;
      end
      if (p == POS_W'(9)) trans_nxt = b;
      if (p == POS_W'(10)) report_nxt = b;

      // Signalling commands are parsed as their bytes go by; a command is
      // applied on its final byte and the next one starts right after it.
      if (p >= POS_W'(9) && kind_r == hidrsp_pkg::PKT_ACL &&
          chan_r == hidrsp_pkg::CID_SIGNALLING && p >= cmd_start_r) begin
        if (off == POS_W'(0)) begin
          cmd_code_nxt = b;
        end else if (off == POS_W'(2)) begin
          cmd_len_nxt = {8'h00, b};
        end else if (off == POS_W'(3)) begin
          cmd_len_nxt[15:8] = b;
        end else if (off >= POS_W'(4) && off < POS_W'(10)) begin
          body_nxt[off_m4[2:0]] = b;
        end
        if (off >= POS_W'(3) &&
            17'(off) == 17'd3 + {1'b0, cmd_len_nxt}) begin
          w0  = {body_nxt[1], body_nxt[0]};
          w1  = {body_nxt[3], body_nxt[2]};
          res = {body_nxt[5], body_nxt[4]};
          if (cmd_code_nxt == hidrsp_pkg::CMD_CONN_REQ && cmd_len_nxt >= 16'd4) begin
            if (w0 == hidrsp_pkg::PSM_HID_CONTROL) begin
              if (dir_r == hidrsp_pkg::DIR_INCOMING) remote_nxt = w1;
              else if (dir_r == hidrsp_pkg::DIR_OUTGOING) local_nxt = w1;
            end
          end else if (cmd_code_nxt == hidrsp_pkg::CMD_CONN_RSP &&
                       cmd_len_nxt >= 16'd8) begin
            if (res == 16'h0000) begin
              if (dir_r == hidrsp_pkg::DIR_INCOMING && w1 == local_r) remote_nxt = w0;
              else if (dir_r == hidrsp_pkg::DIR_OUTGOING && w1 == remote_r) local_nxt = w0;
            end
          end
          cmd_start_nxt = p + POS_W'(1);
        end
      end
      byte_pos_nxt = p + POS_W'(1);
    end

    // Reply decision on the packet as it stands after this byte.
    size = hidrsp_pkg::input_rpt_len(report_nxt);
    reply_ok = in_data.packet_last && enable_reply &&
               kind_nxt == hidrsp_pkg::PKT_ACL &&
               dir_nxt == hidrsp_pkg::DIR_INCOMING &&
               byte_pos_nxt >= POS_W'(9) && chan_nxt == local_nxt &&
               l2len_nxt >= 16'd2 &&
               17'(byte_pos_nxt) >= 17'd9 + {1'b0, l2len_nxt} &&
               trans_nxt == hidrsp_pkg::HID_REQ_INPUT &&
               remote_nxt >= hidrsp_pkg::CID_MIN_DYNAMIC &&
               size != 4'd0;
    req_push = in_fire && reply_ok;
    req_data.link_handle    = handle_nxt;
    req_data.remote_channel = remote_nxt;
    req_data.report_number  = report_nxt;
    req_data.rpt_len        = size;

    if (in_data.packet_last) begin
      byte_pos_nxt  = '0;
      kind_nxt      = '0;
      dir_nxt       = '0;
      handle_nxt    = '0;
      l2len_nxt     = '0;
      chan_nxt      = '0;
      trans_nxt     = '0;
      report_nxt    = '0;
      cmd_start_nxt = POS_W'(9);
      cmd_code_nxt  = '0;
      cmd_len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      kind_r      <= '0;
      dir_r       <= '0;
      handle_r    <= '0;
      l2len_r     <= '0;
      chan_r      <= '0;
      trans_r     <= '0;
      report_r    <= '0;
      cmd_start_r <= POS_W'(9);
      cmd_code_r  <= '0;
      cmd_len_r   <= '0;
      local_r     <= '0;
      remote_r    <= '0;
    end else if (in_fire) begin
      byte_pos_r  <= byte_pos_nxt;
      kind_r      <= kind_nxt;
      dir_r       <= dir_nxt;
      handle_r    <= handle_nxt;
      l2len_r     <= l2len_nxt;
      chan_r      <= chan_nxt;
      trans_r     <= trans_nxt;
      report_r    <= report_nxt;
      cmd_start_r <= cmd_start_nxt;
      cmd_code_r  <= cmd_code_nxt;
      cmd_len_r   <= cmd_len_nxt;
      local_r     <= local_nxt;
      remote_r    <= remote_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      body_r <= body_nxt;
    end
  end

endmodule

/* hw/rtl/hidrsp_queue.sv */
`timescale 1ns / 1ps
module hidrsp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hidrsp_pkg::reply_req_t push_data,
  input  logic                   pop,
  output logic                   full,
  output logic                   not_empty,
  output hidrsp_pkg::reply_req_t pop_data
);

  hidrsp_pkg::reply_req_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/hidrsp_back.sv */
`timescale 1ns / 1ps
module hidrsp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  hidrsp_pkg::reply_req_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hidrsp_pkg::out_word_t  out_data
);

  logic                   busy_r;
  hidrsp_pkg::reply_req_t req_r;
  logic [4:0]             idx_r;
  logic                   out_valid_r;
  hidrsp_pkg::out_word_t  out_data_r;

  logic       adv;
  logic [4:0] total;
  logic [7:0] hid_len;
  logic [7:0] acl_len;
  logic [7:0] byte_val;
  logic       is_last;

  assign q_pop     = !busy_r && q_not_empty;
  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    total   = 5'(req_r.rpt_len) + 5'd10;
    hid_len = 8'(req_r.rpt_len) + 8'd1;
    acl_len = 8'(req_r.rpt_len) + 8'd5;
    is_last = idx_r + 5'd1 == total;
    unique case (idx_r)
      5'd0:    byte_val = hidrsp_pkg::PKT_ACL;
      5'd1:    byte_val = req_r.link_handle[7:0];
      5'd2:    byte_val = {4'h0, req_r.link_handle[11:8]};
      5'd3:    byte_val = acl_len;
      5'd5:    byte_val = hid_len;
      5'd7:    byte_val = req_r.remote_channel[7:0];
      5'd8:    byte_val = req_r.remote_channel[15:8];
      5'd9:    byte_val = hidrsp_pkg::HID_DATA_INPUT;
      5'd10:   byte_val = req_r.report_number;
      default: byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        req_r  <= q_data;
        idx_r  <= '0;
      end
      if (adv) begin
        if (busy_r) begin
          out_valid_r           <= 1'b1;
          out_data_r.reply_byte <= byte_val;
          out_data_r.reply_last <= is_last;
          idx_r                 <= idx_r + 5'd1;
          if (is_last) busy_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

endmodule
